### sv/pw2s_pkg.sv
`timescale 1ns / 1ps
package pw2s_pkg;

  // quotient range: the ratio term clips at 2^QBITS
  localparam int QBITS = 40;

  typedef enum logic [2:0] {
    REG_ROW_X_FIRST  = 3'd0,
    REG_ROW_X_SECOND = 3'd1,
    REG_ROW_Y_FIRST  = 3'd2,
    REG_ROW_Y_SECOND = 3'd3,
    REG_ROW_W_FIRST  = 3'd4,
    REG_ROW_W_SECOND = 3'd5,
    REG_SCREEN_W     = 3'd6,
    REG_SCREEN_H     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic vis;
    logic xneg;
    logic yneg;
    logic xovf;
    logic yovf;
  } side_t;

  typedef struct packed {
    logic [63:0]      rem;
    logic [QBITS-1:0] num;
    logic [63:0]      den;
  } div_in_t;

endpackage

### sv/perspective_world_to_screen.sv
`timescale 1ns / 1ps
// pipeline: a result beat is presented once its input beat has passed through
// six arithmetic stages, 40 divider stages and one output register
// throughput: one point per cycle unless the master side stalls; the quotient needs one stage per bit
// a stall on the master side freezes the whole pipeline in place
// reset (rst, synchronous) clears all valid bits and loads matrix 0, size 1920x1080
module perspective_world_to_screen #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // pos_x, pos_y, pos_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // screen_x, screen_y
  output logic        m_tuser,   // visible
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  pw2s_pkg::reg_idx_t cfg_index,
  input  logic [63:0] cfg_data
);
  import pw2s_pkg::*;

  localparam logic [63:0] WLim = (64'd1 << (2 * FRAC_BITS)) / 64'd1000;
  localparam logic [31:0] Off = 32'(-(64'sd99 <<< FRAC_BITS));
  localparam int NW = 80 + FRAC_BITS - 1;
  localparam int NST = 6 + QBITS + 1;

  logic [63:0] pair_first [0:2];
  logic [63:0] pair_second [0:2];
  logic [15:0] screen_width, screen_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        pair_first[r]  <= '0;
        pair_second[r] <= '0;
      end
      screen_width  <= 16'd1920;
      screen_height <= 16'd1080;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_X_FIRST:  pair_first[0]  <= cfg_data;
        REG_ROW_X_SECOND: pair_second[0] <= cfg_data;
        REG_ROW_Y_FIRST:  pair_first[1]  <= cfg_data;
        REG_ROW_Y_SECOND: pair_second[1] <= cfg_data;
        REG_ROW_W_FIRST:  pair_first[2]  <= cfg_data;
        REG_ROW_W_SECOND: pair_second[2] <= cfg_data;
        REG_SCREEN_W:     screen_width   <= cfg_data[15:0];
        REG_SCREEN_H:     screen_height  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [63:0] mul32s(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] r;
    r = a * b;
    return r;
  endfunction

  logic [NST-1:0] vld;
  logic           en;

  assign en       = !vld[NST-1] || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // stage 1: the nine coordinate products
  logic signed [63:0] s1_prod [0:2][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s1_prod[r][0] <= mul32s(pair_first[r][31:0], s_tdata[31:0]);
        s1_prod[r][1] <= mul32s(pair_first[r][63:32], s_tdata[63:32]);
        s1_prod[r][2] <= mul32s(pair_second[r][31:0], s_tdata[95:64]);
      end
    end
  end

  // stage 2: row sums with the translation term
  logic signed [65:0] s2_sum [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s2_sum[r] <= 66'(s1_prod[r][0]) + 66'(s1_prod[r][1]) + 66'(s1_prod[r][2])
                   + (66'($signed(pair_second[r][63:32])) <<< FRAC_BITS);
      end
    end
  end

  // stage 3: magnitudes and the w threshold
  logic [63:0] s3_mag [0:2];
  logic        s3_neg [0:2];
  logic        s3_vis;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s3_neg[r] <= s2_sum[r][65];
        s3_mag[r] <= s2_sum[r][65] ? 64'(-s2_sum[r]) : s2_sum[r][63:0];
      end
      s3_vis <= !s2_sum[2][65] && (s2_sum[2][63:0] > WLim);
    end
  end

  // stage 4: magnitude times size, in two 32x16 halves
  logic [47:0] s4_plo [0:1];
  logic [47:0] s4_phi [0:1];
  logic [63:0] s4_wmag;
  side_t       s4_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_plo[0] <= s3_mag[0][31:0] * screen_width;
      s4_phi[0] <= s3_mag[0][63:32] * screen_width;
      s4_plo[1] <= s3_mag[1][31:0] * screen_height;
      s4_phi[1] <= s3_mag[1][63:32] * screen_height;
      s4_wmag   <= s3_mag[2];
      s4_sb     <= '{vis: s3_vis, xneg: s3_neg[0], yneg: s3_neg[1], xovf: 1'b0, yovf: 1'b0};
    end
  end

  // stage 5: join the halves
  logic [79:0] s5_num [0:1];
  logic [63:0] s5_wmag;
  side_t       s5_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        s5_num[i] <= {s4_phi[i], 32'd0} + 80'(s4_plo[i]);
      end
      s5_wmag <= s4_wmag;
      s5_sb   <= s4_sb;
    end
  end

  // stage 6: split dividend and flag quotients past the clip
  logic [NW-1:0] full [0:1];
  logic          ovf  [0:1];
  div_in_t       s6_div [0:1];
  side_t         s6_sb;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      full[i] = NW'(s5_num[i]) << (FRAC_BITS - 1);
      ovf[i]  = 64'(full[i][NW-1:QBITS]) >= s5_wmag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        s6_div[i] <= '{rem: 64'(full[i][NW-1:QBITS]), num: full[i][QBITS-1:0],
                       den: s5_wmag};
      end
      s6_sb <= '{vis: s5_sb.vis, xneg: s5_sb.xneg, yneg: s5_sb.yneg,
                 xovf: ovf[0], yovf: ovf[1]};
    end
  end

  logic [QBITS-1:0] qx, qy;

  pw2s_div u_div_x (.clk(clk), .en(en), .din(s6_div[0]), .quo_out(qx));
  pw2s_div u_div_y (.clk(clk), .en(en), .din(s6_div[1]), .quo_out(qy));

  side_t sbd [1:QBITS];

  always_ff @(posedge clk) begin
    if (en) begin
      sbd[1] <= s6_sb;
      for (int k = 2; k <= QBITS; k++) begin
        sbd[k] <= sbd[k-1];
      end
    end
  end

  // output stage: add to the screen center and clip; hidden points get the off-screen value
  logic signed [41:0] half_x, half_y, fx, fy, sx, sy;
  logic        [31:0] cx, cy;
  side_t              sb_last;

  assign sb_last = sbd[QBITS];

  always_comb begin
    half_x = 42'({screen_width, {(FRAC_BITS - 1){1'b0}}});
    half_y = 42'({screen_height, {(FRAC_BITS - 1){1'b0}}});
    fx = sb_last.xovf ? (42'sd1 <<< QBITS) : 42'(qx);
    fy = sb_last.yovf ? (42'sd1 <<< QBITS) : 42'(qy);
    sx = sb_last.xneg ? half_x - fx : half_x + fx;
    sy = sb_last.yneg ? half_y + fy : half_y - fy;
    if (sx > 42'sd2147483647) begin
      cx = 32'h7fff_ffff;
    end else if (sx < -42'sd2147483648) begin
      cx = 32'h8000_0000;
    end else begin
      cx = sx[31:0];
    end
    if (sy > 42'sd2147483647) begin
      cy = 32'h7fff_ffff;
    end else if (sy < -42'sd2147483648) begin
      cy = 32'h8000_0000;
    end else begin
      cy = sy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= sb_last.vis ? {cy, cx} : {Off, Off};
      m_tuser <= sb_last.vis;
    end
  end

  assign m_tvalid = vld[NST-1];

`ifndef SYNTHESIS
  a_off_coords: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[31:0] == Off && m_tdata[63:32] == Off)
    else $error("hidden point without off-screen coordinates");

  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    en && vld[NST-2] |=> m_tvalid)
    else $error("beat lost before output register");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted beat not in first stage");
`endif

endmodule

### sv/pw2s_div.sv
`timescale 1ns / 1ps
module pw2s_div (
  input  logic                      clk,
  input  logic                      en,
  input  pw2s_pkg::div_in_t         din,
  output logic [pw2s_pkg::QBITS-1:0] quo_out
);
  import pw2s_pkg::*;

  // one restoring step per stage, remainder stays below the divisor when the input remainder starts below it
  logic [63:0]      rem [0:QBITS];
  logic [QBITS-1:0] num [0:QBITS];
  logic [63:0]      den [0:QBITS];
  logic [QBITS-1:0] quo [0:QBITS];

  assign rem[0] = din.rem;
  assign num[0] = din.num;
  assign den[0] = din.den;
  assign quo[0] = '0;

  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    logic [64:0] trial;
    logic        ge;
    assign trial = {rem[k-1], num[k-1][QBITS-1]};
    assign ge    = trial >= {1'b0, den[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 64'(trial - {1'b0, den[k-1]}) : trial[63:0];
        num[k] <= {num[k-1][QBITS-2:0], 1'b0};
        den[k] <= den[k-1];
        quo[k] <= {quo[k-1][QBITS-2:0], ge};
      end
    end
  end

  assign quo_out = quo[QBITS];

endmodule
